// ===== design/pcc_pkg.sv =====
package pcc_pkg;

   // Field and datapath widths
   localparam int FRAC_BITS = 16;
   localparam int VAL_W     = 16;
   localparam int ERR_W     = VAL_W + 1;
   localparam int DIFF_W    = ERR_W + 1;
   localparam int MS_W      = 16;
   localparam int WORD_W    = 32;
   localparam int PROD_W    = 2 * WORD_W;
   localparam int FULL_W    = 3 * WORD_W;
   localparam int TERM_W    = 48;
   localparam int INT_W     = 25;
   localparam int SUM_W     = TERM_W + 2;
   localparam int MAG_W     = 62;
   localparam int CSR_IDX_W = 3;

   // Shared divider: radix-4 restoring, two quotient bits per cycle
   localparam int DIV_D_W   = MS_W;
   localparam int DIV_N_W   = WORD_W + FRAC_BITS;
   localparam int DIV_STEPS = (DIV_N_W + 1) / 2;
   localparam int DIV_Q_W   = 2 * DIV_STEPS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
   localparam int INTS_W    = DIV_Q_W + 2;

   // Controller constants
   localparam int INT_HIGH = 200;
   localparam int INT_LOW  = 50;
   localparam int MS_PER_S = 1000;

   localparam logic signed [INTS_W-1:0] INT_HI_LIM =
      INTS_W'(longint'(INT_HIGH) <<< FRAC_BITS);
   localparam logic signed [INTS_W-1:0] INT_LO_LIM =
      INTS_W'(-(longint'(INT_LOW) <<< FRAC_BITS));
   localparam logic [TERM_W:0] TERM_POS_LIM = {2'b00, {(TERM_W-1){1'b1}}};
   localparam logic [TERM_W:0] TERM_NEG_LIM = {2'b01, {(TERM_W-1){1'b0}}};
   localparam logic [MAG_W-1:0] DERIV_SAT   = {MAG_W{1'b1}};

   typedef enum logic {
      REQ_STEP  = 1'b0,
      REQ_CLEAR = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OUT_MAX = 3'd0,
      CSR_OUT_MIN = 3'd1,
      CSR_GAIN_P  = 3'd2,
      CSR_GAIN_I  = 3'd3,
      CSR_GAIN_D  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_INC = 2'd0,
      MUL_DER = 2'd1,
      MUL_LO  = 2'd2,
      MUL_HI  = 2'd3
   } mul_sel_type;

   typedef enum logic {
      DIV_INC = 1'b0,
      DIV_DER = 1'b1
   } div_sel_type;

   typedef enum logic [1:0] {
      TERM_P = 2'd0,
      TERM_I = 2'd1,
      TERM_D = 2'd2
   } term_sel_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] out_max;
      logic signed [WORD_W-1:0] out_min;
      logic [WORD_W-1:0]        gain_p;
      logic [WORD_W-1:0]        gain_i;
      logic [WORD_W-1:0]        gain_d;
   } cfg_type;

   typedef struct packed {
      logic         load;
      logic         mul_en;
      mul_sel_type  mul_sel;
      logic         div_start;
      div_sel_type  div_sel;
      logic         int_upd;
      logic         dmag_upd;
      term_sel_type term_sel;
      logic         lo_save;
      logic         term_wr;
      logic         sum_wr;
      logic         out_wr;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
   } status_type;

endpackage

// ===== design/pcc_if.sv =====
interface pcc_req_if import pcc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    req_type;
   logic signed [VAL_W-1:0] target_value;
   logic signed [VAL_W-1:0] measured_value;
   logic [MS_W-1:0]         elapsed_ms;

   modport source (output valid, req_type, target_value, measured_value, elapsed_ms,
                   input ready);
   modport sink (input valid, req_type, target_value, measured_value, elapsed_ms,
                 output ready);
endinterface

interface pcc_rsp_if import pcc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] drive;
   logic signed [TERM_W-1:0] p_term;
   logic signed [TERM_W-1:0] i_term;
   logic signed [TERM_W-1:0] d_term;
   logic signed [INT_W-1:0]  integral_value;

   modport source (output valid, drive, p_term, i_term, d_term, integral_value,
                   input ready);
   modport sink (input valid, drive, p_term, i_term, d_term, integral_value,
                 output ready);
endinterface

interface pcc_csr_if import pcc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [WORD_W-1:0]    wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

// ===== design/pcc_div.sv =====
module pcc_div import pcc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_Q_W-1:0] dividend,
   input  logic [DIV_D_W-1:0] divisor,
   output logic               busy,
   output logic [DIV_Q_W-1:0] quotient
);

   logic [DIV_Q_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_D_W-1:0]   dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   logic [DIV_D_W:0]   r1, r1s, r2, r2s;
   logic               ge1, ge2;
   logic [DIV_Q_W-1:0] q1, q2;

   // Two restoring steps per cycle; dividend bits shift out as quotient bits shift in
   always_comb begin
      r1  = {rem_ff, quo_ff[DIV_Q_W-1]};
      ge1 = (r1 >= {1'b0, dsr_ff});
      r1s = ge1 ? (r1 - {1'b0, dsr_ff}) : r1;
      q1  = {quo_ff[DIV_Q_W-2:0], ge1};
      r2  = {r1s[DIV_D_W-1:0], q1[DIV_Q_W-1]};
      ge2 = (r2 >= {1'b0, dsr_ff});
      r2s = ge2 ? (r2 - {1'b0, dsr_ff}) : r2;
      q2  = {q1[DIV_Q_W-2:0], ge2};
   end

   // Load on start, otherwise advance while steps remain
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = DIV_CNT_W'(DIV_STEPS);
      end else if (cnt_ff != '0) begin
         quo_in = q2;
         rem_in = r2s[DIV_D_W-1:0];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

endmodule

// ===== design/pcc_dp.sv =====
module pcc_dp import pcc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   input  cfg_type                  cfg,
   input  logic                     req_type,
   input  logic signed [VAL_W-1:0]  target_value,
   input  logic signed [VAL_W-1:0]  measured_value,
   input  logic [MS_W-1:0]          elapsed_ms,
   output status_type               status,
   output logic signed [WORD_W-1:0] drive,
   output logic signed [TERM_W-1:0] p_term,
   output logic signed [TERM_W-1:0] i_term,
   output logic signed [TERM_W-1:0] d_term,
   output logic signed [INT_W-1:0]  integral_value
);

   // Request capture
   logic                     clear_ff, clear_in;
   logic [MS_W-1:0]          elapsed_ff, elapsed_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   // Controller state
   logic signed [ERR_W-1:0]  prev_err_ff, prev_err_in;
   logic signed [INT_W-1:0]  integral_ff, integral_in;
   // Working registers
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [PROD_W-1:0]        lo_ff, lo_in;
   logic [MAG_W-1:0]         dmag_ff, dmag_in;
   logic signed [TERM_W-1:0] p_ff, p_in, i_ff, i_in, d_ff, d_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   // Result registers
   logic signed [WORD_W-1:0] drive_ff, drive_in;
   logic signed [TERM_W-1:0] p_out_ff, p_out_in, i_out_ff, i_out_in, d_out_ff, d_out_in;
   logic signed [INT_W-1:0]  int_out_ff, int_out_in;

   logic signed [ERR_W-1:0]  err_new;
   logic signed [DIFF_W-1:0] diff_new;
   logic [ERR_W-1:0]         err_abs;
   logic [DIFF_W-1:0]        diff_abs;
   logic [INT_W-1:0]         int_abs;
   logic [MAG_W-1:0]         mag;
   logic                     neg;
   logic [WORD_W-1:0]        gain;
   logic [WORD_W-1:0]        mul_a, mul_b;
   logic [DIV_Q_W-1:0]       div_dividend, div_quo;
   logic [DIV_D_W-1:0]       div_divisor;
   logic                     div_busy;
   logic signed [INTS_W-1:0] inc_ext, int_step, int_sum;
   logic signed [INT_W-1:0]  int_next;
   logic [FULL_W-1:0]        full, shifted;
   logic [TERM_W:0]          lim, tmag;
   logic signed [TERM_W-1:0] term_val;
   logic signed [SUM_W-1:0]  max_ext, min_ext;
   logic signed [WORD_W-1:0] drive_val;

   // Error and change of error for the incoming request
   assign err_new  = ERR_W'(target_value) - ERR_W'(measured_value);
   assign diff_new = DIFF_W'(err_new) - DIFF_W'(prev_err_ff);

   assign err_abs  = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);
   assign diff_abs = diff_ff[DIFF_W-1] ? DIFF_W'(-diff_ff) : DIFF_W'(diff_ff);
   assign int_abs  = integral_ff[INT_W-1] ? INT_W'(-integral_ff) : INT_W'(integral_ff);

   // Magnitude, sign and gain of the term being formed
   always_comb begin
      case (cmd.term_sel)
         TERM_P: begin
            mag  = MAG_W'({err_abs, {FRAC_BITS{1'b0}}});
            neg  = err_ff[ERR_W-1];
            gain = cfg.gain_p;
         end
         TERM_I: begin
            mag  = MAG_W'(int_abs);
            neg  = integral_ff[INT_W-1];
            gain = cfg.gain_i;
         end
         TERM_D: begin
            mag  = dmag_ff;
            neg  = diff_ff[DIFF_W-1];
            gain = cfg.gain_d;
         end
         default: begin
            mag  = '0;
            neg  = 1'b0;
            gain = '0;
         end
      endcase
   end

   // Operand select for the shared 32x32 multiplier
   always_comb begin
      case (cmd.mul_sel)
         MUL_INC: begin
            mul_a = WORD_W'(err_abs);
            mul_b = WORD_W'(elapsed_ff);
         end
         MUL_DER: begin
            mul_a = WORD_W'(diff_abs);
            mul_b = WORD_W'(MS_PER_S);
         end
         MUL_LO: begin
            mul_a = mag[WORD_W-1:0];
            mul_b = gain;
         end
         MUL_HI: begin
            mul_a = WORD_W'(mag[MAG_W-1:WORD_W]);
            mul_b = gain;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Both quotients scale the registered product by 2^F
   assign div_dividend = DIV_Q_W'({prod_ff[WORD_W-1:0], {FRAC_BITS{1'b0}}});
   assign div_divisor  = (cmd.div_sel == DIV_INC) ? DIV_D_W'(MS_PER_S) : elapsed_ff;

   pcc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   assign status.div_busy = div_busy;

   // Integral update with clamp
   always_comb begin
      inc_ext  = $signed({2'b00, div_quo});
      int_step = err_ff[ERR_W-1] ? -inc_ext : inc_ext;
      int_sum  = INTS_W'(integral_ff) + int_step;
      if (int_sum > INT_HI_LIM) begin
         int_next = INT_W'(INT_HI_LIM);
      end else if (int_sum < INT_LO_LIM) begin
         int_next = INT_W'(INT_LO_LIM);
      end else begin
         int_next = INT_W'(int_sum);
      end
   end

   // Gained term: combine partial products, drop fraction, saturate, apply sign
   always_comb begin
      full     = {prod_ff, {WORD_W{1'b0}}} + FULL_W'(lo_ff);
      shifted  = full >> FRAC_BITS;
      lim      = neg ? TERM_NEG_LIM : TERM_POS_LIM;
      tmag     = (shifted > FULL_W'(lim)) ? lim : shifted[TERM_W:0];
      term_val = TERM_W'(neg ? (~tmag + 1'b1) : tmag);
   end

   // Output clamp, upper limit tested first
   always_comb begin
      max_ext = SUM_W'(cfg.out_max);
      min_ext = SUM_W'(cfg.out_min);
      if (sum_ff > max_ext) begin
         drive_val = cfg.out_max;
      end else if (sum_ff < min_ext) begin
         drive_val = cfg.out_min;
      end else begin
         drive_val = WORD_W'(sum_ff);
      end
   end

   // Next-state for all registers
   always_comb begin
      clear_in    = clear_ff;
      elapsed_in  = elapsed_ff;
      err_in      = err_ff;
      diff_in     = diff_ff;
      prev_err_in = prev_err_ff;
      integral_in = integral_ff;
      prod_in     = prod_ff;
      lo_in       = lo_ff;
      dmag_in     = dmag_ff;
      p_in        = p_ff;
      i_in        = i_ff;
      d_in        = d_ff;
      sum_in      = sum_ff;
      drive_in    = drive_ff;
      p_out_in    = p_out_ff;
      i_out_in    = i_out_ff;
      d_out_in    = d_out_ff;
      int_out_in  = int_out_ff;

      // Capture the request
      if (cmd.load) begin
         clear_in   = (req_type == REQ_CLEAR);
         elapsed_in = elapsed_ms;
         err_in     = err_new;
         diff_in    = diff_new;
      end

      if (cmd.mul_en) begin
         prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
      end

      if (cmd.lo_save) begin
         lo_in = prod_ff;
      end

      if (cmd.int_upd) begin
         integral_in = int_next;
      end

      // Derivative magnitude: zero for no change, saturate for no elapsed time
      if (cmd.dmag_upd) begin
         if (diff_ff == '0) begin
            dmag_in = '0;
         end else if (elapsed_ff == '0) begin
            dmag_in = DERIV_SAT;
         end else begin
            dmag_in = MAG_W'(div_quo);
         end
      end

      if (cmd.term_wr) begin
         case (cmd.term_sel)
            TERM_P:  p_in = term_val;
            TERM_I:  i_in = term_val;
            TERM_D:  d_in = term_val;
            default: ;
         endcase
      end

      if (cmd.sum_wr) begin
         sum_in = SUM_W'(p_ff) + SUM_W'(i_ff) + SUM_W'(d_ff);
      end

      // Write the result and commit the error history
      if (cmd.out_wr) begin
         if (clear_ff) begin
            drive_in    = '0;
            p_out_in    = '0;
            i_out_in    = '0;
            d_out_in    = '0;
            int_out_in  = '0;
            prev_err_in = '0;
            integral_in = '0;
         end else begin
            drive_in    = drive_val;
            p_out_in    = p_ff;
            i_out_in    = i_ff;
            d_out_in    = d_ff;
            int_out_in  = integral_ff;
            prev_err_in = err_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff <= '0;
         integral_ff <= '0;
      end else begin
         prev_err_ff <= prev_err_in;
         integral_ff <= integral_in;
      end
   end

   always_ff @(posedge clock) begin
      clear_ff   <= clear_in;
      elapsed_ff <= elapsed_in;
      err_ff     <= err_in;
      diff_ff    <= diff_in;
      prod_ff    <= prod_in;
      lo_ff      <= lo_in;
      dmag_ff    <= dmag_in;
      p_ff       <= p_in;
      i_ff       <= i_in;
      d_ff       <= d_in;
      sum_ff     <= sum_in;
      drive_ff   <= drive_in;
      p_out_ff   <= p_out_in;
      i_out_ff   <= i_out_in;
      d_out_ff   <= d_out_in;
      int_out_ff <= int_out_in;
   end

   assign drive          = drive_ff;
   assign p_term         = p_out_ff;
   assign i_term         = i_out_ff;
   assign d_term         = d_out_ff;
   assign integral_value = int_out_ff;

endmodule

// ===== design/pcc_ctrl.sv =====
module pcc_ctrl import pcc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_type,
   input  logic       rsp_ready,
   input  status_type status,
   output logic       req_ready,
   output logic       rsp_valid,
   output cmd_type    cmd
);

   typedef enum logic [11:0] {
      ST_IDLE     = 12'h001,
      ST_MUL_INC  = 12'h002,
      ST_DIV_INC  = 12'h004,
      ST_WAIT_INC = 12'h008,
      ST_MUL_DER  = 12'h010,
      ST_DIV_DER  = 12'h020,
      ST_WAIT_DER = 12'h040,
      ST_MUL_LO   = 12'h080,
      ST_MUL_HI   = 12'h100,
      ST_TERM     = 12'h200,
      ST_SUM      = 12'h400,
      ST_OUT      = 12'h800
   } state_type;

   state_type    state_ff, state_in;
   term_sel_type term_ff, term_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Sequence one request through the shared multiplier and divider
   always_comb begin
      state_in     = state_ff;
      term_in      = term_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            term_in = TERM_P;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_type == REQ_CLEAR) ? ST_OUT : ST_MUL_INC;
            end
         end
         ST_MUL_INC: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_INC;
            state_in    = ST_DIV_INC;
         end
         ST_DIV_INC: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_INC;
            state_in      = ST_WAIT_INC;
         end
         ST_WAIT_INC: begin
            if (!status.div_busy) begin
               cmd.int_upd = 1'b1;
               state_in    = ST_MUL_DER;
            end
         end
         ST_MUL_DER: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DER;
            state_in    = ST_DIV_DER;
         end
         ST_DIV_DER: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_DER;
            state_in      = ST_WAIT_DER;
         end
         ST_WAIT_DER: begin
            if (!status.div_busy) begin
               cmd.dmag_upd = 1'b1;
               state_in     = ST_MUL_LO;
            end
         end
         ST_MUL_LO: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_LO;
            state_in    = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_HI;
            cmd.lo_save = 1'b1;
            state_in    = ST_TERM;
         end
         ST_TERM: begin
            cmd.term_wr = 1'b1;
            if (term_ff == TERM_D) begin
               state_in = ST_SUM;
            end else begin
               term_in  = term_sel_type'(term_ff + 2'd1);
               state_in = ST_MUL_LO;
            end
         end
         ST_SUM: begin
            cmd.sum_wr = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            // Hold until the output register is free
            if (out_free) begin
               cmd.out_wr   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      cmd.term_sel = term_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_ff      <= TERM_P;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/pid_controller_clamped_unit.sv =====
// Control step: the request is sequenced through two radix-4 divisions and the shared
// 32x32 multiplier (two partial products per gained term); no new request is taken until
// the result has been written to the output register.
// Clear request: goes straight to the output state; the next request is taken once it is written.
// A request is taken while an earlier result still waits in the output register.
// Synchronous reset zeroes the gains, the output limits, the integral and the previous error.
module pid_controller_clamped_unit import pcc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   pcc_req_if.sink   req_if,
   pcc_rsp_if.source rsp_if,
   pcc_csr_if.sink   csr_if
);

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_OUT_MAX: cfg_in.out_max = $signed(csr_if.wdata);
            CSR_OUT_MIN: cfg_in.out_min = $signed(csr_if.wdata);
            CSR_GAIN_P:  cfg_in.gain_p  = csr_if.wdata;
            CSR_GAIN_I:  cfg_in.gain_i  = csr_if.wdata;
            CSR_GAIN_D:  cfg_in.gain_d  = csr_if.wdata;
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_if.ready = 1'b1;

   pcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_type  (req_if.req_type),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .cmd       (cmd)
   );

   pcc_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .cfg            (cfg_ff),
      .req_type       (req_if.req_type),
      .target_value   (req_if.target_value),
      .measured_value (req_if.measured_value),
      .elapsed_ms     (req_if.elapsed_ms),
      .status         (status),
      .drive          (rsp_if.drive),
      .p_term         (rsp_if.p_term),
      .i_term         (rsp_if.i_term),
      .d_term         (rsp_if.d_term),
      .integral_value (rsp_if.integral_value)
   );

endmodule

// ===== tb/tb_pid_controller_clamped_unit.sv =====
`timescale 1ns / 1ps

module tb_pid_controller_clamped_unit;
   import pcc_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int PHASE_ITEMS   = 200;
   localparam int HOLD_CYCLES   = 600;
   localparam int SETTLE_CYCLES = 80;

   typedef struct packed {
      req_kind_type            kind;
      logic signed [VAL_W-1:0] target;
      logic signed [VAL_W-1:0] measured;
      logic [MS_W-1:0]         elapsed;
   } pid_request_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] drive;
      logic signed [TERM_W-1:0] p_term;
      logic signed [TERM_W-1:0] i_term;
      logic signed [TERM_W-1:0] d_term;
      logic signed [INT_W-1:0]  integral_value;
   } pid_result_type;

   // Controller predictor: own copy of limits, gains, previous error and integral
   class pid_scoreboard_type;
      logic signed [WORD_W-1:0] drive_hi;
      logic signed [WORD_W-1:0] drive_lo;
      logic [WORD_W-1:0]        kp;
      logic [WORD_W-1:0]        ki;
      logic [WORD_W-1:0]        kd;
      logic signed [ERR_W-1:0]  last_err;
      longint                   integral;
      pid_result_type           due[$];
      int                       errors;
      int                       steps;
      int                       clears;
      int                       checked;

      function new();
         drive_hi = '0;
         drive_lo = '0;
         kp       = '0;
         ki       = '0;
         kd       = '0;
         last_err = '0;
         integral = 0;
         errors   = 0;
         steps    = 0;
         clears   = 0;
         checked  = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [WORD_W-1:0] value);
         case (idx)
            CSR_OUT_MAX: drive_hi = value;
            CSR_OUT_MIN: drive_lo = value;
            CSR_GAIN_P:  kp = value;
            CSR_GAIN_I:  ki = value;
            CSR_GAIN_D:  kd = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return due.size();
      endfunction

      // Scale a sign/magnitude value by a Q16.16 gain, truncate, saturate to the term width
      function logic signed [TERM_W-1:0] apply_gain(logic [63:0] mag, bit neg,
                                                    logic [WORD_W-1:0] gain);
         logic [63:0] lo;
         logic [63:0] hi;
         logic [63:0] lim;
         logic [63:0] r;
         lo  = {32'd0, mag[31:0]} * {32'd0, gain};
         hi  = (mag >> 32) * {32'd0, gain};
         lim = neg ? {16'd0, 1'b1, 47'd0} : {17'd0, {47{1'b1}}};
         if (hi > (lim >> (WORD_W - FRAC_BITS))) begin
            r = lim;
         end else begin
            r = (hi << (WORD_W - FRAC_BITS)) + (lo >> FRAC_BITS);
            if (r > lim) r = lim;
         end
         return neg ? TERM_W'(-r) : TERM_W'(r);
      endfunction

      // Advance the controller state for one accepted request and queue its result
      function void note_request(pid_request_type r);
         longint                   err;
         longint                   diff;
         longint                   hi_lim;
         longint                   lo_lim;
         longint                   sum;
         longint                   clamped;
         logic [63:0]              emag;
         logic [63:0]              inc;
         logic [63:0]              dmag;
         logic [63:0]              imag;
         logic signed [TERM_W-1:0] p;
         logic signed [TERM_W-1:0] i;
         logic signed [TERM_W-1:0] d;
         pid_result_type           want;
         hi_lim = longint'(INT_HIGH) <<< FRAC_BITS;
         lo_lim = -(longint'(INT_LOW) <<< FRAC_BITS);
         want = '0;
         if (r.kind == REQ_CLEAR) begin
            last_err = '0;
            integral = 0;
            clears++;
            due.push_back(want);
            return;
         end
         err  = longint'(r.target) - longint'(r.measured);
         emag = (err < 0) ? -err : err;

         // Integrate error * elapsed / 1000 and clamp
         inc = ((emag * r.elapsed) << FRAC_BITS) / MS_PER_S;
         integral = integral + ((err < 0) ? -longint'(inc) : longint'(inc));
         if (integral > hi_lim) integral = hi_lim;
         else if (integral < lo_lim) integral = lo_lim;

         // Derivative: zero if unchanged, saturated on zero elapsed time
         diff = err - last_err;
         if (diff == 0) dmag = '0;
         else if (r.elapsed == 0) dmag = 64'(DERIV_SAT);
         else dmag = ((((diff < 0) ? -diff : diff) * MS_PER_S) << FRAC_BITS) / r.elapsed;

         imag = (integral < 0) ? -integral : integral;
         p = apply_gain(emag << FRAC_BITS, err < 0, kp);
         i = apply_gain(imag, integral < 0, ki);
         d = apply_gain(dmag, diff < 0, kd);

         // Clamp the sum, upper limit first
         sum = longint'(p) + longint'(i) + longint'(d);
         if (sum > longint'(drive_hi)) clamped = longint'(drive_hi);
         else if (sum < longint'(drive_lo)) clamped = longint'(drive_lo);
         else clamped = sum;

         last_err = ERR_W'(err);
         want.drive          = WORD_W'(clamped);
         want.p_term         = p;
         want.i_term         = i;
         want.d_term         = d;
         want.integral_value = INT_W'(integral);
         steps++;
         due.push_back(want);
      endfunction

      function void check_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      // Compare an accepted result with the oldest outstanding prediction
      function void check_result(pid_result_type got);
         pid_result_type want;
         if (due.size() == 0) begin
            $error("result with no request outstanding: drive %0d", got.drive);
            errors++;
            return;
         end
         want = due.pop_front();
         checked++;
         check_field("drive", longint'(want.drive), longint'(got.drive));
         check_field("p_term", longint'(want.p_term), longint'(got.p_term));
         check_field("i_term", longint'(want.i_term), longint'(got.i_term));
         check_field("d_term", longint'(want.d_term), longint'(got.d_term));
         check_field("integral_value", longint'(want.integral_value),
                     longint'(got.integral_value));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   pcc_req_if req_if ();
   pcc_rsp_if rsp_if ();
   pcc_csr_if csr_if ();

   pid_controller_clamped_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   pid_scoreboard_type sb = new();
   pid_request_type    taken;
   pid_request_type    prev_step;
   pid_result_type     seen;
   bit                 req_idle;
   bit                 rsp_idle;
   int                 rsp_hold;
   int                 cycles;
   int                 settings_applied;

   always #1 clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("pid_controller_clamped_unit test failed");
         $finish;
      end
   end

   // Observe every handshake at the rising edge
   always @(posedge clock) begin
      if (rsp_if.valid && rsp_if.ready) begin
         seen.drive          = rsp_if.drive;
         seen.p_term         = rsp_if.p_term;
         seen.i_term         = rsp_if.i_term;
         seen.d_term         = rsp_if.d_term;
         seen.integral_value = rsp_if.integral_value;
         sb.check_result(seen);
      end
      if (req_if.valid && req_if.ready) begin
         taken.kind     = req_kind_type'(req_if.req_type);
         taken.target   = req_if.target_value;
         taken.measured = req_if.measured_value;
         taken.elapsed  = req_if.elapsed_ms;
         sb.note_request(taken);
      end
      if (csr_if.valid && csr_if.ready)
         sb.write_reg(csr_index_type'(csr_if.index), csr_if.wdata);
   end

   // Offer one request after a random gap when req_idle is set; return at the falling edge after acceptance
   task automatic send_request(pid_request_type r);
      int gap;
      gap = req_idle ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid          = 1'b1;
      req_if.req_type       = r.kind;
      req_if.target_value   = r.target;
      req_if.measured_value = r.measured;
      req_if.elapsed_ms     = r.elapsed;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   task automatic issue(req_kind_type kind, int target, int measured, int elapsed);
      pid_request_type r;
      r.kind     = kind;
      r.target   = VAL_W'(target);
      r.measured = VAL_W'(measured);
      r.elapsed  = MS_W'(elapsed);
      send_request(r);
   endtask

   // Hold the request side until every predicted result has come back
   task automatic wait_drained();
      req_if.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [WORD_W-1:0] value);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.wdata = value;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
   endtask

   task automatic apply_settings(logic [WORD_W-1:0] hi, logic [WORD_W-1:0] lo,
                                 logic [WORD_W-1:0] gp, logic [WORD_W-1:0] gi,
                                 logic [WORD_W-1:0] gd);
      wait_drained();
      write_reg(CSR_OUT_MAX, hi);
      write_reg(CSR_OUT_MIN, lo);
      write_reg(CSR_GAIN_P, gp);
      write_reg(CSR_GAIN_I, gi);
      write_reg(CSR_GAIN_D, gd);
      csr_if.valid = 1'b0;
      settings_applied++;
   endtask

   function automatic logic [WORD_W-1:0] pick_gain();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 32'h0002_0000);
         3: return $urandom_range(0, 32'h0000_1000);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_settings();
      logic [WORD_W-1:0] hi;
      logic [WORD_W-1:0] lo;
      case ($urandom_range(0, 2))
         0: begin
            hi = 32'h7FFF_FFFF;
            lo = 32'h8000_0000;
         end
         1: begin
            // may cross
            hi = $urandom;
            lo = $urandom;
         end
         default: begin
            hi = $urandom_range(0, 32'h7FFF_FFFF);
            lo = -hi;
         end
      endcase
      apply_settings(hi, lo, pick_gain(), pick_gain(), pick_gain());
   endtask

   // Many nearby setpoints so the integral moves, some repeats for unchanged error
   function automatic pid_request_type random_request();
      int              pick;
      pid_request_type r;
      pick   = $urandom_range(0, 99);
      r.kind = (pick < 6) ? REQ_CLEAR : REQ_STEP;
      if (pick >= 6 && pick < 16) begin
         r.target   = prev_step.target;
         r.measured = prev_step.measured;
      end else if (pick < 60) begin
         r.target   = VAL_W'($urandom);
         r.measured = r.target + VAL_W'($urandom_range(0, 400) - 200);
      end else begin
         r.target   = VAL_W'($urandom);
         r.measured = VAL_W'($urandom);
      end
      case ($urandom_range(0, 9))
         0: r.elapsed = '0;
         1, 2, 3, 4, 5, 6: r.elapsed = MS_W'($urandom_range(1, 2000));
         default: r.elapsed = MS_W'($urandom);
      endcase
      if (r.kind == REQ_STEP) prev_step = r;
      return r;
   endfunction

   task automatic run_phase(int items, bit mid_drain);
      for (int n = 0; n < items; n++) begin
         if (mid_drain && n == items / 2) wait_drained();
         send_request(random_request());
      end
   endtask

   // Result side: random stall per result when rsp_idle is set, or one long hold when requested
   task automatic run_receiver();
      int stall;
      forever begin
         stall = rsp_idle ? $urandom_range(0, 5) : 0;
         if (rsp_hold > 0) begin
            stall    = rsp_hold;
            rsp_hold = 0;
         end
         if (stall > 0) begin
            rsp_if.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready = 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         @(negedge clock);
      end
   endtask

   initial begin
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.req_type       = REQ_STEP;
      req_if.target_value   = '0;
      req_if.measured_value = '0;
      req_if.elapsed_ms     = '0;
      rsp_if.ready          = 1'b0;
      csr_if.valid          = 1'b0;
      csr_if.index          = CSR_OUT_MAX;
      csr_if.wdata          = '0;
      req_idle              = 1'b1;
      rsp_idle              = 1'b1;
      rsp_hold              = 0;
      cycles                = 0;
      settings_applied      = 0;
      prev_step             = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      fork
         run_receiver();
      join_none

      // Reset gains and limits: terms and drive come out zero, the integral still moves
      issue(REQ_STEP, 100, 40, 10);
      issue(REQ_CLEAR, 0, 0, 0);

      // Unity gains, full output range: field extremes and derivative corners
      apply_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0001_0000,
                     32'h0001_0000);
      issue(REQ_STEP, 32767, -32768, 65535);
      issue(REQ_STEP, 32767, -32768, 0);
      issue(REQ_STEP, -32768, 32767, 1);
      issue(REQ_STEP, -32768, 32767, 65535);
      issue(REQ_STEP, 0, 0, 0);
      issue(REQ_STEP, -10, 0, 0);
      issue(REQ_STEP, -10, 0, 0);
      issue(REQ_STEP, 5, 5, 65535);
      issue(REQ_CLEAR, -1, 1, 65535);
      issue(REQ_STEP, 3, 1, 1);
      issue(REQ_STEP, 1000, 0, 500);

      // Maximum gains against narrow limits: saturated terms and clamped drive
      apply_settings(32'h0064_0000, 32'hFF9C_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF);
      issue(REQ_STEP, 32767, -32768, 1000);
      issue(REQ_STEP, -32768, 32767, 1);
      issue(REQ_STEP, 7, 0, 0);
      issue(REQ_CLEAR, 0, 0, 0);

      // Crossed limits
      apply_settings(32'hFFFB_0000, 32'h0005_0000, 32'h0000_8000, 32'h0001_0000,
                     32'h0000_0400);
      issue(REQ_STEP, 10, 0, 100);
      issue(REQ_STEP, 0, 10, 100);
      issue(REQ_STEP, 0, 0, 250);

      // Random phases under changing settings and idling patterns
      random_settings();
      run_phase(PHASE_ITEMS, 1'b0);

      req_idle = 1'b0;
      rsp_idle = 1'b0;
      random_settings();
      run_phase(PHASE_ITEMS, 1'b0);

      req_idle = 1'b1;
      rsp_idle = 1'b1;
      random_settings();
      rsp_hold = HOLD_CYCLES;
      run_phase(PHASE_ITEMS, 1'b1);

      rsp_idle = 1'b0;
      apply_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF);
      run_phase(PHASE_ITEMS, 1'b0);

      req_idle = 1'b0;
      rsp_idle = 1'b1;
      random_settings();
      run_phase(PHASE_ITEMS, 1'b0);

      // Drain and let any stray result show up
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d control steps and %0d clears under %0d register settings;",
               sb.steps, sb.clears, settings_applied);
      $display("%0d results compared, incl. saturated terms, crossed limits, long stall.",
               sb.checked);
      if (sb.errors == 0) begin
         $display("pid_controller_clamped_unit test passed");
      end else begin
         $display("pid_controller_clamped_unit test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/pcc_pkg.sv
design/pcc_if.sv
design/pcc_div.sv
design/pcc_dp.sv
design/pcc_ctrl.sv
design/pid_controller_clamped_unit.sv
tb/tb_pid_controller_clamped_unit.sv
